>>> rtl/core/dbc_pkg.sv
// Shared types, widths and codes for the button debounce and click detector.
// Used by the channel interfaces and every module of the block; no dependencies.
`default_nettype none

package dbc_pkg;

  localparam int NUM_BUTTONS = 8;
  localparam int IDX_W       = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

  localparam int BTN_W  = 3;
  localparam int MS_W   = 16;
  localparam int DEB_W  = 10;
  localparam int WIN_W  = 11;
  localparam int MASK_W = 8;
  localparam int CD_W   = 11;
  localparam int ST_W   = 3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK     = 2'd2;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST = 10'd30;
  localparam logic [WIN_W-1:0]  WINDOW_RST   = 11'd350;
  localparam logic [MASK_W-1:0] MASK_RST     = 8'hFF;

  localparam logic FUNC_LEVEL = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  localparam logic KIND_SINGLE = 1'b0;
  localparam logic KIND_DOUBLE = 1'b1;

  localparam logic [ST_W-1:0] ST_IDLE   = 3'd0;
  localparam logic [ST_W-1:0] ST_DEB    = 3'd1;
  localparam logic [ST_W-1:0] ST_DOWN   = 3'd2;
  localparam logic [ST_W-1:0] ST_UPWAIT = 3'd3;
  localparam logic [ST_W-1:0] ST_DBLDEB = 3'd4;
  localparam logic [ST_W-1:0] ST_HELD   = 3'd5;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

  typedef struct packed {
    logic             is_tick;
    logic [IDX_W-1:0] idx;
    logic             pressed;
    logic [MS_W-1:0]  ms;
  } cmd_t;

  typedef struct packed {
    logic [DEB_W-1:0]  debounce_time;
    logic [WIN_W-1:0]  double_window;
    logic [MASK_W-1:0] needs_double_mask;
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/core/dbc_if.sv
// Valid/ready channel interfaces for the input items, the click events and
// configuration writes. Depends on dbc_pkg for field widths.
`default_nettype none

interface dbc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [dbc_pkg::BTN_W-1:0] button_index;
  logic                      pressed;
  logic [dbc_pkg::MS_W-1:0]  elapsed_ms;

  modport source(output valid, func, button_index, pressed, elapsed_ms, input ready);
  modport sink(input valid, func, button_index, pressed, elapsed_ms, output ready);
endinterface

interface dbc_out_if;
  logic                      valid;
  logic                      ready;
  logic [dbc_pkg::BTN_W-1:0] event_button;
  logic                      event_kind;
  logic                      last;

  modport source(output valid, event_button, event_kind, last, input ready);
  modport sink(input valid, event_button, event_kind, last, output ready);
endinterface

interface dbc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dbc_pkg::CFG_IDX_W-1:0]  index;
  logic [dbc_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/button_debounce_click_detector.sv
// A level update passes through the command queue, the sequencer's command register and the
// output register; a tick walks every timer in turn before its last event is registered.
// The sequencer visits one timer per cycle while the output does not stall it, and takes a
// new command only when done with the last; a two-entry queue buffers new transactions.
// Reset (synchronous, active low) sets every input idle with a zero timer, empties the
// queue and the output register, and loads the configuration defaults (30, 350, all ones).
`default_nettype none

module button_debounce_click_detector (
  input  logic      clk,
  input  logic      rst_n,
  dbc_in_if.sink    in_ch,
  dbc_out_if.source out_ch,
  dbc_cfg_if.sink   cfg_ch
);

  logic [dbc_pkg::DEB_W-1:0]  debounce_r;
  logic [dbc_pkg::WIN_W-1:0]  window_r;
  logic [dbc_pkg::MASK_W-1:0] mask_r;
  dbc_pkg::cfg_t              cfg;

  logic                       push_valid;
  logic                       push_ready;
  dbc_pkg::cmd_t              push_cmd;
  logic                       pop_valid;
  logic                       pop_ready;
  dbc_pkg::cmd_t              pop_cmd;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= dbc_pkg::DEBOUNCE_RST;
      window_r   <= dbc_pkg::WINDOW_RST;
      mask_r     <= dbc_pkg::MASK_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dbc_pkg::CFG_DEBOUNCE: debounce_r <= cfg_ch.data[dbc_pkg::DEB_W-1:0];
        dbc_pkg::CFG_WINDOW:   window_r   <= cfg_ch.data[dbc_pkg::WIN_W-1:0];
        dbc_pkg::CFG_MASK:     mask_r     <= cfg_ch.data[dbc_pkg::MASK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg.debounce_time     = debounce_r;
  assign cfg.double_window     = window_r;
  assign cfg.needs_double_mask = mask_r;

  dbc_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  dbc_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  dbc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .cfg       (cfg),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

>>> rtl/core/dbc_front.sv
// Front end: accepts input transactions and turns them into commands.
// Depends on dbc_pkg and dbc_in_if; feeds dbc_cmd_queue.
`default_nettype none

module dbc_front (
  dbc_in_if.sink                in_ch,
  output logic                  push_valid,
  input  logic                  push_ready,
  output dbc_pkg::cmd_t         push_cmd
);

  logic keep;

  // Level updates for missing inputs and ticks of zero time have no effect.
  always_comb begin
    if (in_ch.func == dbc_pkg::FUNC_TICK) begin
      keep = (in_ch.elapsed_ms != '0);
    end else begin
      keep = (32'(in_ch.button_index) < 32'(dbc_pkg::NUM_BUTTONS));
    end
  end

  assign in_ch.ready      = push_ready;
  assign push_valid       = in_ch.valid && keep;
  assign push_cmd.is_tick = (in_ch.func == dbc_pkg::FUNC_TICK);
  assign push_cmd.idx     = dbc_pkg::IDX_W'(in_ch.button_index);
  assign push_cmd.pressed = in_ch.pressed;
  assign push_cmd.ms      = in_ch.elapsed_ms;

endmodule

`default_nettype wire

>>> rtl/core/dbc_cmd_queue.sv
// Short command queue between the front end and the sequencer.
// Depends on dbc_pkg for the command type and depth.
`default_nettype none

module dbc_cmd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  dbc_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output dbc_pkg::cmd_t pop_cmd
);

  dbc_pkg::cmd_t                entry_r [dbc_pkg::Q_DEPTH];
  logic [dbc_pkg::Q_AW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [dbc_pkg::Q_AW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [dbc_pkg::Q_AW:0]       count_r, count_nxt;
  logic                         do_push, do_pop;

  assign push_ready = (count_r != (dbc_pkg::Q_AW + 1)'(dbc_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == dbc_pkg::Q_AW'(dbc_pkg::Q_DEPTH - 1)) ? '0 :
                   wr_ptr_r + dbc_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == dbc_pkg::Q_AW'(dbc_pkg::Q_DEPTH - 1)) ? '0 :
                   rd_ptr_r + dbc_pkg::Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + (dbc_pkg::Q_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (dbc_pkg::Q_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/dbc_back.sv
// Sequencer: holds each input's click state and timer, applies level updates,
// walks all timers on a tick and emits click events. Depends on dbc_pkg, dbc_out_if.
`default_nettype none

module dbc_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  dbc_pkg::cmd_t cmd,
  input  dbc_pkg::cfg_t cfg,
  dbc_out_if.source     out_ch
);

  typedef enum logic [3:0] {
    SQ_IDLE  = 4'b0001,
    SQ_LEVEL = 4'b0010,
    SQ_WALK  = 4'b0100,
    SQ_DONE  = 4'b1000
  } seq_state_t;

  localparam int N = dbc_pkg::NUM_BUTTONS;

  seq_state_t                   seq_r, seq_nxt;
  dbc_pkg::cmd_t                cmd_r, cmd_nxt;
  logic [dbc_pkg::IDX_W-1:0]    addr_r, addr_nxt;
  logic [dbc_pkg::ST_W-1:0]     st_mem_r [N];
  logic [dbc_pkg::CD_W-1:0]     cd_mem_r [N];

  logic                         pend_v_r, pend_v_nxt;
  logic [dbc_pkg::BTN_W-1:0]    pend_btn_r, pend_btn_nxt;
  logic                         pend_kind_r, pend_kind_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [dbc_pkg::BTN_W-1:0]    out_btn_r, out_btn_nxt;
  logic                         out_kind_r, out_kind_nxt;
  logic                         out_last_r, out_last_nxt;

  logic [dbc_pkg::ST_W-1:0]     cur_st;
  logic [dbc_pkg::CD_W-1:0]     cur_cd;
  logic [31:0]                  addr_ext;
  logic                         wants_double;

  logic [dbc_pkg::ST_W-1:0]     lvl_st;
  logic [dbc_pkg::CD_W-1:0]     lvl_cd;
  logic                         lvl_fire;
  logic                         lvl_kind;

  logic [dbc_pkg::ST_W-1:0]     tck_st;
  logic [dbc_pkg::CD_W-1:0]     tck_cd;
  logic                         tck_fire;
  logic                         tck_kind;

  logic                         wr_en;
  logic [dbc_pkg::ST_W-1:0]     wr_st;
  logic [dbc_pkg::CD_W-1:0]     wr_cd;
  logic                         push;
  logic [dbc_pkg::BTN_W-1:0]    push_btn;
  logic                         push_kind;
  logic                         push_last;
  logic                         out_free;

  assign cur_st   = st_mem_r[addr_r];
  assign cur_cd   = cd_mem_r[addr_r];
  assign addr_ext = 32'(addr_r);
  assign out_free = !out_valid_r || out_ch.ready;

  // Inputs beyond the mask width always tell single from double.
  assign wants_double = (addr_ext >= 32'd8) ? 1'b1 : cfg.needs_double_mask[addr_ext[2:0]];

  always_comb begin
    lvl_st   = cur_st;
    lvl_cd   = cur_cd;
    lvl_fire = 1'b0;
    lvl_kind = dbc_pkg::KIND_DOUBLE;
    unique case (cur_st)
      dbc_pkg::ST_IDLE: begin
        if (cmd_r.pressed) begin
          lvl_st = dbc_pkg::ST_DEB;
          lvl_cd = dbc_pkg::CD_W'(cfg.debounce_time);
        end
      end
      dbc_pkg::ST_DEB, dbc_pkg::ST_HELD: begin
        if (!cmd_r.pressed) begin
          lvl_st = dbc_pkg::ST_IDLE;
          lvl_cd = '0;
        end
      end
      dbc_pkg::ST_DOWN: begin
        if (!cmd_r.pressed) begin
          lvl_st = dbc_pkg::ST_UPWAIT;
          lvl_cd = cfg.double_window;
        end
      end
      dbc_pkg::ST_UPWAIT: begin
        if (cmd_r.pressed) begin
          lvl_st = dbc_pkg::ST_DBLDEB;
          lvl_cd = dbc_pkg::CD_W'(cfg.debounce_time);
        end
      end
      dbc_pkg::ST_DBLDEB: begin
        if (!cmd_r.pressed) begin
          lvl_st   = dbc_pkg::ST_IDLE;
          lvl_cd   = '0;
          lvl_fire = 1'b1;
        end
      end
      default: begin
        lvl_st = dbc_pkg::ST_IDLE;
        lvl_cd = '0;
      end
    endcase
  end

  always_comb begin
    tck_st   = cur_st;
    tck_cd   = cur_cd;
    tck_fire = 1'b0;
    tck_kind = dbc_pkg::KIND_SINGLE;
    if (cur_cd != '0) begin
      if (cmd_r.ms >= dbc_pkg::MS_W'(cur_cd)) begin
        tck_cd = '0;
        unique case (cur_st)
          dbc_pkg::ST_DEB: begin
            if (wants_double) begin
              tck_st = dbc_pkg::ST_DOWN;
            end else begin
              tck_st   = dbc_pkg::ST_HELD;
              tck_fire = 1'b1;
            end
          end
          dbc_pkg::ST_UPWAIT: begin
            tck_st   = dbc_pkg::ST_IDLE;
            tck_fire = 1'b1;
          end
          dbc_pkg::ST_DBLDEB: begin
            tck_st   = dbc_pkg::ST_IDLE;
            tck_fire = 1'b1;
            tck_kind = dbc_pkg::KIND_DOUBLE;
          end
          default: begin
            tck_st = dbc_pkg::ST_IDLE;
          end
        endcase
      end else begin
        tck_cd = cur_cd - dbc_pkg::CD_W'(cmd_r.ms);
      end
    end
  end

  always_comb begin
    seq_nxt       = seq_r;
    cmd_nxt       = cmd_r;
    addr_nxt      = addr_r;
    cmd_ready     = 1'b0;
    wr_en         = 1'b0;
    wr_st         = tck_st;
    wr_cd         = tck_cd;
    push          = 1'b0;
    push_btn      = pend_btn_r;
    push_kind     = pend_kind_r;
    push_last     = 1'b0;
    pend_v_nxt    = pend_v_r;
    pend_btn_nxt  = pend_btn_r;
    pend_kind_nxt = pend_kind_r;
    unique case (seq_r)
      SQ_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          cmd_nxt = cmd;
          if (cmd.is_tick) begin
            addr_nxt = '0;
            seq_nxt  = SQ_WALK;
          end else begin
            addr_nxt = cmd.idx;
            seq_nxt  = SQ_LEVEL;
          end
        end
      end
      SQ_LEVEL: begin
        if (!lvl_fire || out_free) begin
          wr_en     = 1'b1;
          wr_st     = lvl_st;
          wr_cd     = lvl_cd;
          push      = lvl_fire;
          push_btn  = dbc_pkg::BTN_W'(addr_r);
          push_kind = lvl_kind;
          push_last = 1'b1;
          seq_nxt   = SQ_IDLE;
        end
      end
      SQ_WALK: begin
        // An event is held back until the next one fires or the walk ends, so that the final one can be marked last.
        if (!(tck_fire && pend_v_r) || out_free) begin
          wr_en = 1'b1;
          if (tck_fire) begin
            push          = pend_v_r;
            pend_v_nxt    = 1'b1;
            pend_btn_nxt  = dbc_pkg::BTN_W'(addr_r);
            pend_kind_nxt = tck_kind;
          end
          if (addr_r == dbc_pkg::IDX_W'(N - 1)) begin
            seq_nxt = SQ_DONE;
          end else begin
            addr_nxt = addr_r + dbc_pkg::IDX_W'(1);
          end
        end
      end
      SQ_DONE: begin
        if (!pend_v_r || out_free) begin
          push       = pend_v_r;
          push_last  = 1'b1;
          pend_v_nxt = 1'b0;
          seq_nxt    = SQ_IDLE;
        end
      end
      default: begin
        seq_nxt = SQ_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_btn_nxt   = out_btn_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_valid_nxt = 1'b1;
      out_btn_nxt   = push_btn;
      out_kind_nxt  = push_kind;
      out_last_nxt  = push_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= SQ_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        st_mem_r[i] <= dbc_pkg::ST_IDLE;
        cd_mem_r[i] <= '0;
      end
    end else begin
      seq_r       <= seq_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (wr_en) begin
        st_mem_r[addr_r] <= wr_st;
        cd_mem_r[addr_r] <= wr_cd;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    addr_r      <= addr_nxt;
    pend_btn_r  <= pend_btn_nxt;
    pend_kind_r <= pend_kind_nxt;
    out_btn_r   <= out_btn_nxt;
    out_kind_r  <= out_kind_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_button = out_btn_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for the button debounce and click detector.
// Drives level and tick transactions, predicts click events per input and checks them.
// Depends on dbc_pkg, the channel interfaces and button_debounce_click_detector.
module testbench;
  import dbc_pkg::*;

  localparam int DRAIN_CYCLES    = 40;
  localparam int QUIET_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic             func;
    logic [BTN_W-1:0] button;
    logic             pressed;
    logic [MS_W-1:0]  elapsed;
  } btn_item_t;

  typedef struct packed {
    logic [BTN_W-1:0] button;
    logic             kind;
    logic             last;
  } click_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  dbc_in_if  in_ch();
  dbc_out_if out_ch();
  dbc_cfg_if cfg_ch();

  button_debounce_click_detector DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #1 clk = ~clk;

  btn_item_t item_queue[$];
  click_t    expected_clicks[$];

  logic [ST_W-1:0]   btn_state [NUM_BUTTONS] = '{default: ST_IDLE};
  logic [CD_W-1:0]   btn_timer [NUM_BUTTONS] = '{default: '0};
  logic [DEB_W-1:0]  deb_ms   = DEBOUNCE_RST;
  logic [WIN_W-1:0]  win_ms   = WINDOW_RST;
  logic [MASK_W-1:0] dbl_mask = MASK_RST;

  int send_gap_pct = 0;
  int recv_gap_pct = 0;
  int stall_asks   = 0;
  int stall_seen   = 0;
  int hold_left    = 0;
  int bad_count    = 0;
  int quiet_cycles = 0;

  function automatic click_t make_click(input int b, input logic kind);
    click_t c;
    c.button = BTN_W'(b);
    c.kind   = kind;
    c.last   = 1'b0;
    return c;
  endfunction

  task automatic track_clicks(input btn_item_t it);
    click_t fired[$];
    int b;
    b = int'(it.button);
    if (it.func == FUNC_LEVEL) begin
      if (b < NUM_BUTTONS) begin
        case (btn_state[b])
          ST_IDLE: begin
            if (it.pressed) begin
              btn_state[b] = ST_DEB;
              btn_timer[b] = CD_W'(deb_ms);
            end
          end
          ST_DEB, ST_HELD: begin
            if (!it.pressed) begin
              btn_state[b] = ST_IDLE;
              btn_timer[b] = '0;
            end
          end
          ST_DOWN: begin
            if (!it.pressed) begin
              btn_state[b] = ST_UPWAIT;
              btn_timer[b] = CD_W'(win_ms);
            end
          end
          ST_UPWAIT: begin
            if (it.pressed) begin
              btn_state[b] = ST_DBLDEB;
              btn_timer[b] = CD_W'(deb_ms);
            end
          end
          ST_DBLDEB: begin
            if (!it.pressed) begin
              btn_state[b] = ST_IDLE;
              btn_timer[b] = '0;
              fired.push_back(make_click(b, KIND_DOUBLE));
            end
          end
          default: begin
            btn_state[b] = ST_IDLE;
            btn_timer[b] = '0;
          end
        endcase
      end
    end else begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (btn_timer[i] != '0) begin
          if (it.elapsed >= MS_W'(btn_timer[i])) begin
            btn_timer[i] = '0;
            case (btn_state[i])
              ST_DEB: begin
                if (i >= MASK_W || dbl_mask[i]) begin
                  btn_state[i] = ST_DOWN;
                end else begin
                  btn_state[i] = ST_HELD;
                  fired.push_back(make_click(i, KIND_SINGLE));
                end
              end
              ST_UPWAIT: begin
                btn_state[i] = ST_IDLE;
                fired.push_back(make_click(i, KIND_SINGLE));
              end
              ST_DBLDEB: begin
                btn_state[i] = ST_IDLE;
                fired.push_back(make_click(i, KIND_DOUBLE));
              end
              default: begin
                btn_state[i] = ST_IDLE;
              end
            endcase
          end else begin
            btn_timer[i] = btn_timer[i] - CD_W'(it.elapsed);
          end
        end
      end
    end
    if (fired.size() > 0) begin
      fired[fired.size()-1].last = 1'b1;
    end
    foreach (fired[k]) begin
      expected_clicks.push_back(fired[k]);
    end
  endtask

  always @(posedge clk) begin : driver
    btn_item_t seen;
    btn_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen.func    = in_ch.func;
        seen.button  = in_ch.button_index;
        seen.pressed = in_ch.pressed;
        seen.elapsed = in_ch.elapsed_ms;
        track_clicks(seen);
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (item_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          nxt = item_queue.pop_front();
          in_ch.valid        <= 1'b1;
          in_ch.func         <= nxt.func;
          in_ch.button_index <= nxt.button;
          in_ch.pressed      <= nxt.pressed;
          in_ch.elapsed_ms   <= nxt.elapsed;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    click_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_clicks.size() == 0) begin
          if (bad_count < 10) begin
            $display("unexpected click event: button %0d kind %0d last %0d",
                     out_ch.event_button, out_ch.event_kind, out_ch.last);
          end
          bad_count++;
        end else begin
          want = expected_clicks.pop_front();
          if (out_ch.event_button !== want.button || out_ch.event_kind !== want.kind ||
              out_ch.last !== want.last) begin
            if (bad_count < 10) begin
              $display("click mismatch: expected button %0d kind %0d last %0d, got %0d %0d %0d",
                       want.button, want.kind, want.last,
                       out_ch.event_button, out_ch.event_kind, out_ch.last);
            end
            bad_count++;
          end
        end
      end
      if (stall_asks != stall_seen) begin
        stall_seen   <= stall_asks;
        hold_left    <= HOLD_OFF_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic add_item(input logic f, input int b, input logic p, input int ms);
    btn_item_t it;
    it.func    = f;
    it.button  = BTN_W'(b);
    it.pressed = p;
    it.elapsed = MS_W'(ms);
    item_queue.push_back(it);
  endtask

  task automatic add_level(input int b, input logic p);
    add_item(FUNC_LEVEL, b, p, $urandom_range(16'hFFFF));
  endtask

  task automatic add_tick(input int ms);
    add_item(FUNC_TICK, $urandom_range(NUM_BUTTONS-1), 1'($urandom_range(1)), ms);
  endtask

  task automatic add_click_run();
    int b;
    int deb_i;
    int win_i;
    int short_deb;
    int short_win;
    b         = $urandom_range(NUM_BUTTONS-1);
    deb_i     = int'(deb_ms);
    win_i     = int'(win_ms);
    short_deb = (deb_i > 1) ? $urandom_range(deb_i-1) : 0;
    short_win = (win_i > 1) ? $urandom_range(win_i-1) : 0;
    case ($urandom_range(9))
      0, 1, 2: begin
        add_level(b, 1'b1);
        add_tick(deb_i + $urandom_range(3));
        add_level(b, 1'b0);
        add_tick(win_i + $urandom_range(3));
      end
      3, 4: begin
        add_level(b, 1'b1);
        add_tick(deb_i + $urandom_range(3));
        add_level(b, 1'b0);
        add_tick(short_win);
        add_level(b, 1'b1);
        add_tick(deb_i + $urandom_range(3));
      end
      5: begin
        add_level(b, 1'b1);
        add_tick(deb_i);
        add_level(b, 1'b0);
        add_level(b, 1'b1);
        add_level(b, 1'b0);
      end
      6: begin
        add_level(b, 1'b1);
        add_tick(short_deb);
        add_level(b, 1'b0);
      end
      default: begin
        repeat ($urandom_range(1, 3)) begin
          add_item(1'($urandom_range(1)), $urandom_range(NUM_BUTTONS-1),
                   1'($urandom_range(1)),
                   ($urandom_range(3) == 0) ? $urandom_range(16'hFFFF)
                                            : $urandom_range(2 * win_i + 2));
        end
      end
    endcase
  endtask

  task automatic wait_quiet();
    while (item_queue.size() != 0 || in_ch.valid || expected_clicks.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= CFG_DATA_W'(value);
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: deb_ms   = DEB_W'(value);
      CFG_WINDOW:   win_ms   = WIN_W'(value);
      CFG_MASK:     dbl_mask = MASK_W'(value);
      default: ;
    endcase
  endtask

  task automatic run_phase(input int deb, input int win, input int mask, input int runs);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_WINDOW, win);
    write_reg(CFG_MASK, mask);
    repeat (runs) add_click_run();
  endtask

  initial begin : main
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_LEVEL;
    in_ch.button_index = '0;
    in_ch.pressed      = 1'b0;
    in_ch.elapsed_ms   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_DEBOUNCE;
    cfg_ch.data        = '0;
    send_gap_pct = 6;
    recv_gap_pct = 50;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Every input through a full single click, expiring together on one tick.
    for (int i = 0; i < NUM_BUTTONS; i++) add_level(i, 1'b1);
    add_tick(0);
    add_tick(16'hFFFF);
    for (int i = 0; i < NUM_BUTTONS; i++) add_level(i, 1'b0);
    add_tick(16'hFFFF);
    // A timed double click on input 1 and a bounce in the second press on input 2.
    add_level(1, 1'b1);
    add_level(2, 1'b1);
    add_tick(30);
    add_level(1, 1'b0);
    add_level(2, 1'b0);
    add_level(1, 1'b1);
    add_level(2, 1'b1);
    add_level(2, 1'b0);
    add_tick(30);
    add_level(3, 1'b1);
    add_level(3, 1'b0);
    wait_quiet();

    run_phase(1, 1, 8'h00, 6);
    wait_quiet();

    send_gap_pct = 50;
    recv_gap_pct = 6;
    stall_asks++;
    run_phase(1000, 2000, 8'hFF, 6);
    wait_quiet();

    run_phase(0, 0, $urandom_range(8'hFF), 3);
    wait_quiet();
    repeat (3) add_click_run();
    wait_quiet();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    run_phase($urandom_range(1, 1000), $urandom_range(1, 2000), $urandom_range(8'hFF), 4);
    wait_quiet();
    run_phase($urandom_range(1, 60), $urandom_range(1, 100), $urandom_range(8'hFF), 4);
    wait_quiet();

    if (bad_count == 0 && expected_clicks.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> button_debounce_click_detector.f
rtl/core/dbc_pkg.sv
rtl/core/dbc_if.sv
rtl/core/dbc_front.sv
rtl/core/dbc_cmd_queue.sv
rtl/core/dbc_back.sv
rtl/core/button_debounce_click_detector.sv
tb/testbench.sv
